/* hw/rtl/slte_pkg.sv */
package slte_pkg;

	localparam int KEY_W    = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int NODE_W   = 6;
	localparam int COUNT_W  = 7;

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

/* hw/rtl/slte_ram.sv */
module slte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/sorted_list_table_engine.sv */
// Search, and insert or delete that fails: the request walks the list nodes (at most the element
// count), then passes S_DEC and S_RESP into the result register. Insert that links a node adds the
// link writes of S_INS1 and S_INS2, delete that unlinks a node adds S_DEL2; insert into a full store goes to S_RESP.
// The walk does one node per cycle through the registered read of the key and link memories.
// Clear sweeps all NODES link entries, one rewritten per cycle, then passes S_RESP. One item at
// a time: the next transfer can come in the cycle after the result loads.
// Reset (arst_n low, asynchronous) empties the list; a sweep through all NODES entries then
// rebuilds the free chain in the link memory with in_stall high.
module sorted_list_table_engine #(
	parameter int NODES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [slte_pkg::FUNC_W-1:0]   func,
	input  logic signed [slte_pkg::KEY_W-1:0] key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [slte_pkg::STATUS_W-1:0] status,
	output logic [slte_pkg::NODE_W-1:0]   node_index,
	output logic [slte_pkg::COUNT_W-1:0]  count
);

	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_INS1 = 3'd4;
	localparam logic [2:0] S_INS2 = 3'd5;
	localparam logic [2:0] S_DEL2 = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	// link format: {valid, index}
	logic [2:0]                          state_q;
	logic [IW-1:0]                       sweep_q;
	logic                                clr_resp_q;
	logic [slte_pkg::FUNC_W-1:0]         op_q;
	logic signed [slte_pkg::KEY_W-1:0]   key_q;
	logic [IW:0]                         cur_q;
	logic [IW:0]                         prev_q;
	logic [IW:0]                         cur_link_q;
	logic                                eq_q;
	logic [IW:0]                         list_head_q;
	logic [IW:0]                         free_head_q;
	logic [CW-1:0]                       count_q;
	logic [slte_pkg::STATUS_W-1:0]       status_q;
	logic [IW-1:0]                       node_q;
	logic                                out_valid_q;
	logic [slte_pkg::STATUS_W-1:0]       out_status_q;
	logic [slte_pkg::NODE_W-1:0]         out_node_q;
	logic [slte_pkg::COUNT_W-1:0]        out_count_q;

	logic                                re;
	logic [IW-1:0]                       raddr;
	logic                                key_we;
	logic [IW-1:0]                       key_waddr;
	logic [slte_pkg::KEY_W-1:0]          key_rd;
	logic                                link_we;
	logic [IW-1:0]                       link_waddr;
	logic [IW:0]                         link_wdata;
	logic [IW:0]                         link_rd;

	logic                                accept;
	logic                                walk_lt;
	logic                                found;
	logic                                resp_load;
	logic [IW:0]                         sweep_nxt;
	logic [IW:0]                         clr_link;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign walk_lt   = $signed(key_rd) < key_q;
	assign found     = cur_q[IW] && eq_q;
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);
	assign sweep_nxt = {1'b0, sweep_q} + (IW+1)'(1);
	assign clr_link  = {(sweep_nxt < (IW+1)'(NODES)), sweep_nxt[IW-1:0]};

	slte_ram #(.WIDTH(slte_pkg::KEY_W), .DEPTH(NODES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.re    (re),
		.raddr (raddr),
		.rdata (key_rd)
	);

	slte_ram #(.WIDTH(IW + 1), .DEPTH(NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (link_rd)
	);

	always_comb begin
		re         = 1'b0;
		raddr      = list_head_q[IW-1:0];
		key_we     = 1'b0;
		key_waddr  = free_head_q[IW-1:0];
		link_we    = 1'b0;
		link_waddr = sweep_q;
		link_wdata = clr_link;
		unique case (state_q)
			S_CLR: begin
				link_we = 1'b1;
			end
			S_IDLE: begin
				if (accept && func != slte_pkg::OP_CLEAR && list_head_q[IW] &&
						!(func == slte_pkg::OP_INSERT && !free_head_q[IW])) begin
					re = 1'b1;
				end
			end
			S_WALK: begin
				raddr = link_rd[IW-1:0];
				if (walk_lt && link_rd[IW]) begin
					re = 1'b1;
				end
			end
			S_DEC: begin
				raddr = free_head_q[IW-1:0];
				if (op_q == slte_pkg::OP_INSERT && !found) begin
					re     = 1'b1;
					key_we = 1'b1;
				end
				if (op_q == slte_pkg::OP_DELETE && found && prev_q[IW]) begin
					link_we    = 1'b1;
					link_waddr = prev_q[IW-1:0];
					link_wdata = cur_link_q;
				end
			end
			S_INS1: begin
				link_we    = 1'b1;
				link_waddr = node_q;
				link_wdata = cur_q;
			end
			S_INS2: begin
				link_we    = prev_q[IW];
				link_waddr = prev_q[IW-1:0];
				link_wdata = {1'b1, node_q};
			end
			S_DEL2: begin
				link_we    = 1'b1;
				link_waddr = node_q;
				link_wdata = free_head_q;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			sweep_q     <= '0;
			clr_resp_q  <= 1'b0;
			list_head_q <= '0;
			free_head_q <= {1'b1, {IW{1'b0}}};
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					sweep_q <= sweep_nxt[IW-1:0];
					if (sweep_q == IW'(NODES - 1)) begin
						sweep_q    <= '0;
						clr_resp_q <= 1'b0;
						state_q    <= clr_resp_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (func == slte_pkg::OP_CLEAR) begin
							list_head_q <= '0;
							free_head_q <= {1'b1, {IW{1'b0}}};
							count_q     <= '0;
							clr_resp_q  <= 1'b1;
							state_q     <= S_CLR;
						end else if (func == slte_pkg::OP_INSERT && !free_head_q[IW]) begin
							state_q <= S_RESP;
						end else if (list_head_q[IW]) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_DEC;
						end
					end
				end
				S_WALK: begin
					if (!walk_lt || !link_rd[IW]) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q == slte_pkg::OP_INSERT && !found) begin
						state_q <= S_INS1;
					end else if (op_q == slte_pkg::OP_DELETE && found) begin
						if (!prev_q[IW]) begin
							list_head_q <= cur_link_q;
						end
						state_q <= S_DEL2;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_INS1: begin
					free_head_q <= link_rd;
					state_q     <= S_INS2;
				end
				S_INS2: begin
					if (!prev_q[IW]) begin
						list_head_q <= {1'b1, node_q};
					end
					count_q <= count_q + CW'(1);
					state_q <= S_RESP;
				end
				S_DEL2: begin
					free_head_q <= {1'b1, node_q};
					if (count_q != '0) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_CLR: begin
				status_q <= slte_pkg::ST_OK;
				node_q   <= '0;
			end
			S_IDLE: begin
				op_q     <= func;
				key_q    <= key;
				cur_q    <= list_head_q;
				prev_q   <= '0;
				eq_q     <= 1'b0;
				status_q <= slte_pkg::ST_FULL;
				node_q   <= '0;
			end
			S_WALK: begin
				if (walk_lt) begin
					prev_q <= cur_q;
					cur_q  <= link_rd;
				end else begin
					eq_q       <= ($signed(key_rd) == key_q);
					cur_link_q <= link_rd;
				end
			end
			S_DEC: begin
				node_q <= '0;
				case (op_q)
					slte_pkg::OP_INSERT: begin
						status_q <= slte_pkg::ST_DUPLICATE;
						if (!found) begin
							node_q <= free_head_q[IW-1:0];
						end
					end
					slte_pkg::OP_DELETE, slte_pkg::OP_SEARCH: begin
						status_q <= slte_pkg::ST_NOT_FOUND;
						if (found) begin
							status_q <= slte_pkg::ST_OK;
							node_q   <= cur_q[IW-1:0];
						end
					end
					default: begin
						status_q <= slte_pkg::ST_OK;
					end
				endcase
			end
			S_INS2: begin
				status_q <= slte_pkg::ST_OK;
			end
			default: begin
			end
		endcase
		if (resp_load) begin
			out_status_q <= status_q;
			out_node_q   <= slte_pkg::NODE_W'(node_q);
			out_count_q  <= slte_pkg::COUNT_W'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign node_index = out_node_q;
	assign count      = out_count_q;

endmodule

/* hw/rtl/slte_checker.sv */
module slte_checker #(
	parameter int NODES = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [slte_pkg::STATUS_W-1:0] status,
	input logic [slte_pkg::NODE_W-1:0]   node_index,
	input logic [slte_pkg::COUNT_W-1:0]  count
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
			$stable(node_index) && $stable(count))
		else $error("stalled result changed");

	// a failed request reports node zero
	a_fail_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != slte_pkg::ST_OK |-> node_index == '0)
		else $error("failed request with nonzero node index");

	// a full store means every node is on the list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == slte_pkg::ST_FULL |->
			count == slte_pkg::COUNT_W'(NODES))
		else $error("store full reported with free nodes left");

	// one item at a time: a transfer closes the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

endmodule

bind sorted_list_table_engine slte_checker #(.NODES(NODES)) u_slte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.node_index (node_index),
	.count      (count)
);

/* bench/sorted_list_table_engine_tb.sv */
module sorted_list_table_engine_tb;

	localparam int NODES = 64;
	localparam int POOL = 96;
	localparam int ITEM_TARGET = 1775;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = NODES + 16;

	typedef struct {
		logic [slte_pkg::FUNC_W-1:0] func;
		logic signed [slte_pkg::KEY_W-1:0] key;
		bit hold_empty;
	} list_req_t;

	typedef struct {
		logic [slte_pkg::STATUS_W-1:0] status;
		logic [slte_pkg::NODE_W-1:0] node;
		logic [slte_pkg::COUNT_W-1:0] cnt;
	} list_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [slte_pkg::FUNC_W-1:0] func = slte_pkg::OP_INSERT;
	logic signed [slte_pkg::KEY_W-1:0] key = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [slte_pkg::STATUS_W-1:0] status;
	logic [slte_pkg::NODE_W-1:0] node_index;
	logic [slte_pkg::COUNT_W-1:0] count;

	list_req_t request_q[$];
	list_res_t answer_q[$];
	int issued_n = 0;
	int done_n = 0;
	int total_n = 0;
	int err_n = 0;
	int cycle_n = 0;

	// shadow of the node store
	logic signed [slte_pkg::KEY_W-1:0] key_mem [NODES];
	int link_nx [NODES];
	bit link_ok [NODES];
	int head_nx, free_nx, elem_n;
	bit head_ok, free_ok;

	logic signed [slte_pkg::KEY_W-1:0] pool [POOL];

	sorted_list_table_engine #(
		.NODES(NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.node_index(node_index),
		.count(count)
	);

	function automatic void table_rebuild();
		for (int i = 0; i < NODES; i++) begin
			link_nx[i] = i + 1;
			link_ok[i] = (i + 1) < NODES;
		end
		head_nx = 0;
		head_ok = 1'b0;
		free_nx = 0;
		free_ok = 1'b1;
		elem_n = 0;
	endfunction

	function automatic list_res_t table_apply(input logic [slte_pkg::FUNC_W-1:0] op,
			input logic signed [slte_pkg::KEY_W-1:0] k);
		list_res_t r;
		int p, c, n, steps;
		bit p_ok, c_ok, hit;
		r.status = slte_pkg::ST_OK;
		r.node = '0;
		if (op == slte_pkg::OP_CLEAR) begin
			table_rebuild();
		end else if (op == slte_pkg::OP_INSERT && !free_ok) begin
			r.status = slte_pkg::ST_FULL;
		end else begin
			p = 0;
			p_ok = 1'b0;
			c = head_nx;
			c_ok = head_ok;
			steps = 0;
			// stop at the first node whose key is not below k
			while (c_ok && steps < NODES && key_mem[c] < k) begin
				p = c;
				p_ok = 1'b1;
				c_ok = link_ok[c];
				c = link_nx[c];
				steps++;
			end
			hit = c_ok && key_mem[c] == k;
			case (op)
				slte_pkg::OP_INSERT: begin
					if (hit) begin
						r.status = slte_pkg::ST_DUPLICATE;
					end else begin
						n = free_nx;
						free_ok = link_ok[n];
						free_nx = link_nx[n];
						key_mem[n] = k;
						if (!p_ok) begin
							link_nx[n] = head_nx;
							link_ok[n] = head_ok;
							head_nx = n;
							head_ok = 1'b1;
						end else begin
							link_nx[n] = link_nx[p];
							link_ok[n] = link_ok[p];
							link_nx[p] = n;
							link_ok[p] = 1'b1;
						end
						elem_n++;
						r.node = n[slte_pkg::NODE_W-1:0];
					end
				end
				slte_pkg::OP_DELETE: begin
					if (!hit) begin
						r.status = slte_pkg::ST_NOT_FOUND;
					end else begin
						if (!p_ok) begin
							head_nx = link_nx[c];
							head_ok = link_ok[c];
						end else begin
							link_nx[p] = link_nx[c];
							link_ok[p] = link_ok[c];
						end
						link_nx[c] = free_nx;
						link_ok[c] = free_ok;
						free_nx = c;
						free_ok = 1'b1;
						if (elem_n > 0)
							elem_n--;
						r.node = c[slte_pkg::NODE_W-1:0];
					end
				end
				default: begin
					if (hit)
						r.node = c[slte_pkg::NODE_W-1:0];
					else
						r.status = slte_pkg::ST_NOT_FOUND;
				end
			endcase
		end
		r.cnt = elem_n[slte_pkg::COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_req(input logic [slte_pkg::FUNC_W-1:0] op,
			input logic signed [slte_pkg::KEY_W-1:0] k);
		list_req_t q;
		q.func = op;
		q.key = k;
		q.hold_empty = 1'b0;
		request_q.push_back(q);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("result %0d: %s is %0d, expected %0d", done_n, what, got, want);
		err_n++;
	endtask

	function automatic int sender_idle_pct();
		int ph;
		ph = issued_n * 3 / total_n;
		return ph == 0 ? 32 : (ph == 1 ? 61 : 0);
	endfunction

	function automatic int receiver_stall_pct();
		int ph;
		ph = issued_n * 3 / total_n;
		return ph == 0 ? 61 : (ph == 1 ? 32 : 0);
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk)
		cycle_n <= cycle_n + 1;

	initial begin
		wait (cycle_n >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin : drive
		list_req_t nxt;
		list_res_t r;
		bit took;
		if (arst_n) begin
			took = in_valid && !in_stall;
			if (took) begin
				r = table_apply(func, key);
				answer_q.push_back(r);
				issued_n <= issued_n + 1;
				void'(request_q.pop_front());
			end
			if (in_valid && !took) begin
				// hold the stalled transfer
			end else if (request_q.size() > 0) begin
				nxt = request_q[0];
				if (nxt.hold_empty && issued_n + int'(took) != done_n)
					in_valid <= 1'b0;
				else if ($urandom_range(0, 99) < sender_idle_pct())
					in_valid <= 1'b0;
				else begin
					in_valid <= 1'b1;
					func <= nxt.func;
					key <= nxt.key;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : observe
		list_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (done_n == issued_n) begin
					report_mismatch("unrequested result, status", int'(status), 0);
				end else begin
					want = answer_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", int'(status), int'(want.status));
					if (node_index !== want.node)
						report_mismatch("node_index", int'(node_index), int'(want.node));
					if (count !== want.cnt)
						report_mismatch("count", int'(count), int'(want.cnt));
					done_n <= done_n + 1;
				end
			end
			out_stall <= $urandom_range(0, 99) < receiver_stall_pct();
		end
	end

	initial begin
		int off, len, w, first_rand;
		logic [31:0] rnd;
		logic signed [slte_pkg::KEY_W-1:0] k;
		logic [slte_pkg::FUNC_W-1:0] op;
		bit first_seq;

		for (int i = 0; i < NODES; i++)
			key_mem[i] = '0;
		table_rebuild();

		// distinct keys: the low seven bits carry the pool slot
		for (int i = 0; i < POOL; i++) begin
			rnd = $urandom();
			pool[i] = {rnd[31:7], 7'(i)};
		end

		add_req(slte_pkg::OP_SEARCH, 0);
		add_req(slte_pkg::OP_DELETE, 5);
		add_req(slte_pkg::OP_INSERT, 0);
		add_req(slte_pkg::OP_INSERT, 32'sh7FFFFFFF);
		add_req(slte_pkg::OP_INSERT, 32'sh80000000);
		add_req(slte_pkg::OP_INSERT, -1);
		add_req(slte_pkg::OP_INSERT, 1);
		add_req(slte_pkg::OP_INSERT, 0);
		add_req(slte_pkg::OP_INSERT, 32'sh80000000);
		add_req(slte_pkg::OP_SEARCH, 32'sh80000000);
		add_req(slte_pkg::OP_SEARCH, 32'sh7FFFFFFF);
		add_req(slte_pkg::OP_SEARCH, 0);
		add_req(slte_pkg::OP_SEARCH, 2);
		add_req(slte_pkg::OP_DELETE, 32'sh80000000);
		add_req(slte_pkg::OP_DELETE, 32'sh7FFFFFFF);
		add_req(slte_pkg::OP_DELETE, 0);
		add_req(slte_pkg::OP_DELETE, 0);
		add_req(slte_pkg::OP_INSERT, 32'sh80000000);
		add_req(slte_pkg::OP_CLEAR, 0);
		add_req(slte_pkg::OP_SEARCH, -1);
		add_req(slte_pkg::OP_INSERT, -1);
		add_req(slte_pkg::OP_CLEAR, 0);
		add_req(slte_pkg::OP_CLEAR, 0);

		first_rand = request_q.size();
		first_seq = 1'b1;
		while (request_q.size() < ITEM_TARGET) begin
			w = first_seq ? 0 : $urandom_range(0, 9);
			first_seq = 1'b0;
			off = $urandom_range(0, POOL - 1);
			if (w <= 1) begin
				// fill the store past full, then hit it with a present and a new key
				if ($urandom_range(0, 1))
					add_req(slte_pkg::OP_CLEAR, $urandom());
				len = $urandom_range(66, 72);
				for (int j = 0; j < len; j++)
					add_req(slte_pkg::OP_INSERT, pool[(off + j) % POOL]);
				add_req(slte_pkg::OP_INSERT, pool[off]);
				add_req(slte_pkg::OP_INSERT, $urandom());
				add_req(slte_pkg::OP_SEARCH, pool[(off + 3) % POOL]);
			end else if (w == 2) begin
				len = $urandom_range(10, 60);
				for (int j = 0; j < len; j++)
					add_req(slte_pkg::OP_DELETE, pool[(off + j) % POOL]);
			end else if (w == 3) begin
				add_req(slte_pkg::OP_CLEAR, $urandom());
			end else begin
				for (int j = 0; j < 20; j++) begin
					w = $urandom_range(0, 99);
					op = w < 40 ? slte_pkg::OP_INSERT : (w < 65 ? slte_pkg::OP_DELETE :
						(w < 97 ? slte_pkg::OP_SEARCH : slte_pkg::OP_CLEAR));
					if ($urandom_range(0, 99) < 85)
						k = pool[$urandom_range(0, POOL - 1)];
					else
						k = $urandom();
					add_req(op, k);
				end
			end
		end

		total_n = request_q.size();
		// let the store settle at the start of the random part and at each idling change
		request_q[first_rand].hold_empty = 1'b1;
		request_q[total_n / 3].hold_empty = 1'b1;
		request_q[2 * total_n / 3].hold_empty = 1'b1;

		while (request_q.size() != 0 || issued_n != done_n)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_n == 0 && answer_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
